// ===== src/kmna_pkg.sv =====
package kmna_pkg;

	localparam int CRD_W  = 16;  // Q8.8 coordinate
	localparam int SQ_W   = 32;  // one squared difference, Q16.16
	localparam int DIST_W = 40;  // accumulated squared distance
	localparam int PIDX_W = 3;   // index fields at the ports

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_POINT = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// control from the top level to every distance lane
	typedef struct packed {
		logic              adv;     // whole pipe moves this cycle
		logic              load;    // center coordinate write, dimension in range
		logic [PIDX_W-1:0] center;  // center being loaded
		logic              acc_s1;  // stage 1 holds a point coordinate that counts
		logic              pt_s2;   // stage 2 holds a point coordinate
		logic              fin_s2;  // stage 2 holds the last coordinate of a point
	} lane_ctl_t;

	// what travels beside the min tree
	typedef struct packed {
		logic              fin;
		logic              clr;
		logic [PIDX_W-1:0] prev;
	} tag_t;

endpackage

// ===== src/kmna_lane.sv =====
module kmna_lane #(
	parameter int NUM_DIMS = 16,
	parameter int LANE     = 0,
	parameter int DIW      = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  kmna_pkg::lane_ctl_t          ctl,
	input  logic [DIW-1:0]               addr,
	input  logic [kmna_pkg::CRD_W-1:0]   wdata,
	input  logic [kmna_pkg::CRD_W-1:0]   value_s1,
	output logic [kmna_pkg::DIST_W-1:0]  dist_s3
);

	logic [kmna_pkg::CRD_W-1:0]  bank [NUM_DIMS];
	logic [kmna_pkg::CRD_W-1:0]  rd_s1;
	logic [kmna_pkg::CRD_W:0]    diff;
	logic [kmna_pkg::CRD_W-1:0]  mag;
	logic [kmna_pkg::SQ_W-1:0]   sq;
	logic [kmna_pkg::SQ_W-1:0]   sq_s2;
	logic [kmna_pkg::DIST_W-1:0] partial_q;
	logic [kmna_pkg::DIST_W:0]   sum;
	logic [kmna_pkg::DIST_W-1:0] sum_sat;
	logic                        we;

	assign we = ctl.load && (32'(ctl.center) == LANE);

	// this center's coordinates, one entry per dimension
	always_ff @(posedge clk) begin
		if (we)
			bank[addr] <= wdata;
		if (ctl.adv)
			rd_s1 <= bank[addr];
	end

	// |diff| never exceeds 65535, so the square is 16x16
	assign diff = {value_s1[kmna_pkg::CRD_W-1], value_s1} - {rd_s1[kmna_pkg::CRD_W-1], rd_s1};
	assign mag  = diff[kmna_pkg::CRD_W] ? kmna_pkg::CRD_W'(-diff) : diff[kmna_pkg::CRD_W-1:0];
	assign sq   = mag * mag;

	always_ff @(posedge clk) begin
		if (ctl.adv)
			sq_s2 <= ctl.acc_s1 ? sq : '0;
	end

	assign sum     = {1'b0, partial_q} + (kmna_pkg::DIST_W + 1)'(sq_s2);
	assign sum_sat = sum[kmna_pkg::DIST_W] ? '1 : sum[kmna_pkg::DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
		end else if (ctl.adv && ctl.pt_s2) begin
			partial_q <= ctl.fin_s2 ? '0 : sum_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv && ctl.pt_s2 && ctl.fin_s2)
			dist_s3 <= sum_sat;
	end

endmodule

// ===== src/kmeans_nearest_center_assign.sv =====
// Channel | dir | handshake           | word
// --------+-----+---------------------+---------------------------------------------------
// cfg     | in  | cfg_wr_en           | cfg_wr_data = active_centers
// in      | in  | in_valid / in_stall | action, center_index, coord_index, coord_value,
//         |     |                     | last_coord, prev_assignment
// out     | out | out_valid/out_stall | assignment, min_distance, changed, cluster_count,
//         |     |                     | objective_total, changed_total
//
// One input word per cycle sustained while no result sits unread under out_stall. After its
// last coordinate is taken, a result passes bank read, square, accumulate, one register
// per level of the registered min tree, then the output register with counts and totals.
// Reset clears accumulators, counts, totals and pipe valid bits; center banks are not
// cleared and must be loaded before use. The pipe moves as one: while a result sits
// unread under out_stall, in_stall is raised and nothing inside moves.
module kmeans_nearest_center_assign #(
	parameter int CENTER_CNT = 8,
	parameter int NUM_DIMS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_wr_en,
	input  logic [3:0]         cfg_wr_data,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic [2:0]         center_index,
	input  logic [3:0]         coord_index,
	input  logic signed [15:0] coord_value,
	input  logic               last_coord,
	input  logic [2:0]         prev_assignment,

	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         assignment,
	output logic [39:0]        min_distance,
	output logic               changed,
	output logic [31:0]        cluster_count,
	output logic [63:0]        objective_total,
	output logic [31:0]        changed_total
);

	localparam int CW     = $clog2(CENTER_CNT);
	localparam int LEVELS = CW;
	localparam int P      = 1 << CW;                 // leaves, padded to a power of two
	localparam int DIW    = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
	localparam int CIW    = (DIW > 4) ? DIW : 4;
	localparam int AW     = (CW > kmna_pkg::PIDX_W) ? CW : kmna_pkg::PIDX_W;
	localparam int DW     = kmna_pkg::DIST_W;

	// ---------------- configuration
	logic [3:0] active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 4'd8;
		end else if (cfg_wr_en) begin
			active_q <= cfg_wr_data;
		end
	end

	// ---------------- flow control: one enable for the whole pipe
	logic adv;
	logic acc;
	logic dim_ok;
	logic [CIW-1:0] cidx_ext;
	logic [DIW-1:0] addr;

	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;
	assign acc      = in_valid && adv;
	assign dim_ok   = 32'(coord_index) < NUM_DIMS;
	assign cidx_ext = CIW'(coord_index);
	assign addr     = cidx_ext[DIW-1:0];

	// ---------------- stages 1..3 control and payload
	logic        pt_s1, fin_s1, clr_s1, okpt_s1;
	logic        pt_s2, fin_s2, clr_s2;
	logic        fin_s3, clr_s3;
	logic [15:0] value_s1;
	logic [2:0]  prev_s1, prev_s2, prev_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_s1   <= 1'b0;
			fin_s1  <= 1'b0;
			clr_s1  <= 1'b0;
			okpt_s1 <= 1'b0;
			pt_s2   <= 1'b0;
			fin_s2  <= 1'b0;
			clr_s2  <= 1'b0;
			fin_s3  <= 1'b0;
			clr_s3  <= 1'b0;
		end else if (adv) begin
			pt_s1   <= in_valid && (action == kmna_pkg::ACT_POINT);
			fin_s1  <= in_valid && (action == kmna_pkg::ACT_POINT) && last_coord;
			clr_s1  <= in_valid && (action == kmna_pkg::ACT_CLEAR);
			// out-of-range dimension adds nothing but can still end the point
			okpt_s1 <= in_valid && (action == kmna_pkg::ACT_POINT) && dim_ok;
			pt_s2   <= pt_s1;
			fin_s2  <= fin_s1;
			clr_s2  <= clr_s1;
			fin_s3  <= fin_s2;
			clr_s3  <= clr_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_s1 <= coord_value;
			prev_s1  <= prev_assignment;
			prev_s2  <= prev_s1;
			prev_s3  <= prev_s2;
		end
	end

	// ---------------- one distance lane per center
	kmna_pkg::lane_ctl_t lane_ctl;
	logic [DW-1:0]       lane_d [CENTER_CNT];

	assign lane_ctl = '{
		adv:    adv,
		load:   acc && (action == kmna_pkg::ACT_LOAD) && dim_ok,
		center: center_index,
		acc_s1: okpt_s1,
		pt_s2:  pt_s2,
		fin_s2: fin_s2
	};

	for (genvar c = 0; c < CENTER_CNT; c++) begin : g_lane
		kmna_lane #(
			.NUM_DIMS (NUM_DIMS),
			.LANE     (c),
			.DIW      (DIW)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (lane_ctl),
			.addr     (addr),
			.wdata    (coord_value),
			.value_s1 (value_s1),
			.dist_s3  (lane_d[c])
		);
	end

	// ---------------- registered min tree
	// Heap order: node n takes children 2n and 2n+1, node 1 is the root. The right
	// child wins only when strictly smaller, which keeps ties on the lower index.
	// Inactive and padding leaves never win; center 0 is always active.
	logic [DW-1:0] leaf_d [P];
	logic [CW-1:0] leaf_i [P];
	logic          leaf_a [P];
	logic [DW-1:0] node_d_q [1:P-1];
	logic [CW-1:0] node_i_q [1:P-1];
	logic          node_a_q [1:P-1];

	for (genvar c = 0; c < P; c++) begin : g_leaf
		if (c < CENTER_CNT) begin : g_real
			assign leaf_d[c] = lane_d[c];
			assign leaf_a[c] = (c == 0) || (32'(active_q) > c);
		end else begin : g_pad
			assign leaf_d[c] = '0;
			assign leaf_a[c] = 1'b0;
		end
		assign leaf_i[c] = CW'(c);
	end

	for (genvar n = 1; n < P; n++) begin : g_node
		logic [DW-1:0] ld, rd;
		logic [CW-1:0] li, ri;
		logic          la, ra;

		if (2 * n >= P) begin : g_from_leaf
			assign ld = leaf_d[2*n-P];
			assign li = leaf_i[2*n-P];
			assign la = leaf_a[2*n-P];
			assign rd = leaf_d[2*n+1-P];
			assign ri = leaf_i[2*n+1-P];
			assign ra = leaf_a[2*n+1-P];
		end else begin : g_from_node
			assign ld = node_d_q[2*n];
			assign li = node_i_q[2*n];
			assign la = node_a_q[2*n];
			assign rd = node_d_q[2*n+1];
			assign ri = node_i_q[2*n+1];
			assign ra = node_a_q[2*n+1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (ra && (!la || (rd < ld))) begin
					node_d_q[n] <= rd;
					node_i_q[n] <= ri;
					node_a_q[n] <= ra;
				end else begin
					node_d_q[n] <= ld;
					node_i_q[n] <= li;
					node_a_q[n] <= la;
				end
			end
		end
	end

	// end-of-point and clear marks ride beside the tree, one register per level
	kmna_pkg::tag_t tag_q [LEVELS];
	kmna_pkg::tag_t root_tag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '{default: '0};
		end else if (adv) begin
			tag_q[0] <= '{fin: fin_s3, clr: clr_s3, prev: prev_s3};
			for (int k = 1; k < LEVELS; k++)
				tag_q[k] <= tag_q[k-1];
		end
	end

	assign root_tag = tag_q[LEVELS-1];

	// ---------------- counts, totals and the output register
	logic [CW-1:0] root_i;
	logic [DW-1:0] root_d;
	logic [31:0]   cnt_q [CENTER_CNT];
	logic [63:0]   obj_q;
	logic [31:0]   chg_q;
	logic [31:0]   cnt_sel, cnt_inc;
	logic [64:0]   obj_sum;
	logic [63:0]   obj_new;
	logic          is_chg;
	logic [31:0]   chg_new;
	logic          out_valid_q;
	logic [CW-1:0] asg_q;
	logic [DW-1:0] dist_q;
	logic          chg_bit_q;
	logic [31:0]   cnt_out_q;

	assign root_i  = node_i_q[1];
	assign root_d  = node_d_q[1];
	assign cnt_sel = cnt_q[root_i];
	assign cnt_inc = (&cnt_sel) ? cnt_sel : cnt_sel + 32'd1;
	assign obj_sum = {1'b0, obj_q} + 65'(root_d);
	assign obj_new = obj_sum[64] ? '1 : obj_sum[63:0];
	assign is_chg  = AW'(root_i) != AW'(root_tag.prev);
	assign chg_new = (is_chg && !(&chg_q)) ? chg_q + 32'd1 : chg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			obj_q       <= '0;
			chg_q       <= '0;
			cnt_q       <= '{default: '0};
		end else if (adv) begin
			out_valid_q <= root_tag.fin;
			if (root_tag.clr) begin
				obj_q <= '0;
				chg_q <= '0;
				cnt_q <= '{default: '0};
			end else if (root_tag.fin) begin
				obj_q <= obj_new;
				chg_q <= chg_new;
				for (int c = 0; c < CENTER_CNT; c++) begin
					if (32'(root_i) == c)
						cnt_q[c] <= cnt_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && root_tag.fin) begin
			asg_q     <= root_i;
			dist_q    <= root_d;
			chg_bit_q <= is_chg;
			cnt_out_q <= cnt_inc;
		end
	end

	// totals are frozen while a result waits, so they are shown straight from state
	assign out_valid       = out_valid_q;
	assign assignment      = kmna_pkg::PIDX_W'(asg_q);
	assign min_distance    = dist_q;
	assign changed         = chg_bit_q;
	assign cluster_count   = cnt_out_q;
	assign objective_total = obj_q;
	assign changed_total   = chg_q;

`ifndef SYNTHESIS
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cluster_count != 32'd0))
		else $error("result with zero cluster count");

	a_obj_covers_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (objective_total >= 64'(min_distance)))
		else $error("objective total below the reported distance");

	a_changed_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && changed) |-> (changed_total != 32'd0))
		else $error("changed result but changed total is zero");

	a_winner_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((asg_q == '0) || (32'(asg_q) < 32'(active_q))))
		else $error("winner outside the active centers");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for kmeans_nearest_center_assign.
//
// Stimulus: the center store is filled first, since a point coordinate reads every
// center's entry of its dimension. A short directed run covers ties, field extremes,
// ignored and clear actions, and accumulator saturation. Random phases follow, each
// under its own active_centers setting: mostly well-formed points of random length with
// random content, plus center reloads, clears and unused-action noise.
//
// Checking: every accepted input word goes through an in-bench model of the block.
// The model keeps its own centers, partial sums, counts and totals. Each point end
// queues one expected result, and every result taken on the out channel is compared
// field by field against the oldest entry in that queue.
module tb_top;

	localparam int NC = 8;
	localparam int ND = 16;

	// action code the block ignores; it gets no name in the package
	localparam logic [1:0] ACT_SPARE = 2'd3;

	localparam int IDLE_PCT    = 38;
	localparam int DRAIN       = 20;    // pipe is 4 + log2(NC) deep, plus margin
	localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills the pipe
	localparam int QUIET_LIMIT = 5000;  // cycles with no handshake before giving up
	localparam int PHASE_WORDS = 132;

	localparam longint unsigned DIST_MAX = (64'd1 << 40) - 64'd1;

	typedef struct packed {
		logic [2:0]  asg;
		logic [39:0] mdist;
		logic        chg;
		logic [31:0] cnt;
		logic [63:0] obj;
		logic [31:0] ctot;
	} assign_res_t;

	// Tracks the block state word by word and holds the results still due.
	class nearest_center_score;
		bit signed [15:0] centers [NC][ND];
		longint unsigned  partial [NC];
		bit [31:0]        counts [NC];
		bit [63:0]        obj_sum;
		bit [31:0]        chg_sum;
		bit [3:0]         active;
		assign_res_t      due_assignments [$];
		int               errors;
		int               checked;
		int               loads;
		int               clears;

		function new();
			int c;
			for (c = 0; c < NC; c++) begin
				partial[c] = 0;
				counts[c]  = 0;
			end
			obj_sum = 0;
			chg_sum = 0;
			active  = 4'd8;
		endfunction

		function void set_active(bit [3:0] v);
			active = v;
		endfunction

		task report(string what, logic [63:0] got_v, logic [63:0] want_v);
			errors++;
			$display("%0t mismatch on %0s: got %0h, want %0h", $realtime, what, got_v,
				want_v);
		endtask

		function void take_word(logic [1:0] act, logic [2:0] cidx, logic [3:0] dim,
				logic signed [15:0] val, logic last, logic [2:0] prev);
			int c;
			int diff;
			int n;
			int best;
			longint unsigned sq;
			longint unsigned acc;
			longint unsigned best_d;
			bit [63:0] tot;
			assign_res_t r;
			case (act)
				kmna_pkg::ACT_LOAD: begin
					centers[cidx][dim] = val;
					loads++;
				end
				kmna_pkg::ACT_CLEAR: begin
					// partial sums and centers survive a clear
					for (c = 0; c < NC; c++)
						counts[c] = 0;
					obj_sum = 0;
					chg_sum = 0;
					clears++;
				end
				kmna_pkg::ACT_POINT: begin
					for (c = 0; c < NC; c++) begin
						diff = int'(val) - int'(centers[c][dim]);
						if (diff < 0)
							diff = -diff;
						sq  = longint'(diff) * longint'(diff);
						acc = partial[c] + sq;
						partial[c] = (acc > DIST_MAX) ? DIST_MAX : acc;
					end
					if (last) begin
						// 0 searches one center, anything above NC searches all
						n = int'(active);
						if (n < 1)
							n = 1;
						if (n > NC)
							n = NC;
						best   = 0;
						best_d = partial[0];
						for (c = 1; c < n; c++) begin
							if (partial[c] < best_d) begin
								best_d = partial[c];
								best   = c;
							end
						end
						r.asg   = best[2:0];
						r.mdist = best_d[39:0];
						r.chg   = (best != int'(prev));
						if (counts[best] != '1)
							counts[best]++;
						tot = obj_sum + best_d;
						obj_sum = (tot < obj_sum) ? '1 : tot;
						if (r.chg && chg_sum != '1)
							chg_sum++;
						r.cnt  = counts[best];
						r.obj  = obj_sum;
						r.ctot = chg_sum;
						due_assignments = {due_assignments, r};
						for (c = 0; c < NC; c++)
							partial[c] = 0;
					end
				end
				default: ;
			endcase
		endfunction

		task match_result(assign_res_t got);
			assign_res_t want;
			if (due_assignments.size() == 0) begin
				report("result with none due", 64'(got.asg), 64'd0);
				return;
			end
			want = due_assignments.pop_front();
			checked++;
			if (got.asg !== want.asg)
				report("assignment", 64'(got.asg), 64'(want.asg));
			if (got.mdist !== want.mdist)
				report("min_distance", 64'(got.mdist), 64'(want.mdist));
			if (got.chg !== want.chg)
				report("changed", 64'(got.chg), 64'(want.chg));
			if (got.cnt !== want.cnt)
				report("cluster_count", 64'(got.cnt), 64'(want.cnt));
			if (got.obj !== want.obj)
				report("objective_total", got.obj, want.obj);
			if (got.ctot !== want.ctot)
				report("changed_total", 64'(got.ctot), 64'(want.ctot));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [3:0]         cfg_wr_data;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         action;
	logic [2:0]         center_index;
	logic [3:0]         coord_index;
	logic signed [15:0] coord_value;
	logic               last_coord;
	logic [2:0]         prev_assignment;
	logic               out_valid;
	logic               out_stall;
	logic [2:0]         assignment;
	logic [39:0]        min_distance;
	logic               changed;
	logic [31:0]        cluster_count;
	logic [63:0]        objective_total;
	logic [31:0]        changed_total;

	nearest_center_score score = new();

	int idle_pct = IDLE_PCT;  // shared by sender and receiver; 0 during the calm phase
	bit hold_due;             // asks the receiver for one long hold-off
	int words_sent;           // words that the block acts on, action 3 excluded
	int settings_used;
	int quiet;

	kmeans_nearest_center_assign #(
		.CENTER_CNT(NC),
		.NUM_DIMS(ND)
	) dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Offer one word and return at the edge that takes it. Random idle cycles go in
	// front; valid stays high from one word to the next when no idle is drawn.
	task automatic put_word(logic [1:0] act, logic [2:0] cidx, logic [3:0] dim,
			logic signed [15:0] val, logic last, logic [2:0] prev);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		action          <= act;
		center_index    <= cidx;
		coord_index     <= dim;
		coord_value     <= val;
		last_coord      <= last;
		prev_assignment <= prev;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		score.take_word(act, cidx, dim, val, last, prev);
		if (act != ACT_SPARE)
			words_sent++;
	endtask

	// Coordinate values lean on the extremes of the Q8.8 range.
	function automatic logic signed [15:0] rnd_coord();
		case ($urandom_range(7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_point();
		int len;
		int i;
		// mostly 1 to 16 coordinates, now and then 17 to 48; dimensions are random, so repeats occur
		len = ($urandom_range(19) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
		for (i = 0; i < len; i++)
			put_word(kmna_pkg::ACT_POINT, 3'($urandom_range(7)), 4'($urandom_range(15)),
				rnd_coord(), i == len - 1, 3'($urandom_range(7)));
	endtask

	task automatic random_phase(int n);
		int start;
		int pick;
		start = words_sent;
		while (words_sent - start < n) begin
			pick = $urandom_range(99);
			if (pick < 72) begin
				random_point();
			end else if (pick < 88) begin
				repeat ($urandom_range(1, 4))
					put_word(kmna_pkg::ACT_LOAD, 3'($urandom_range(7)),
						4'($urandom_range(15)), rnd_coord(), 1'($urandom),
						3'($urandom_range(7)));
			end else if (pick < 91) begin
				put_word(kmna_pkg::ACT_CLEAR, 3'($urandom_range(7)), 4'($urandom_range(15)),
					16'($urandom), 1'($urandom), 3'($urandom_range(7)));
			end else begin
				put_word(ACT_SPARE, 3'($urandom_range(7)), 4'($urandom_range(15)),
					16'($urandom), 1'($urandom), 3'($urandom_range(7)));
			end
		end
	endtask

	// Drop valid, let every due result out, then give a trailing load or clear time
	// to clear the pipe before touching the register.
	task automatic settle();
		in_valid <= 1'b0;
		while (score.due_assignments.size() != 0)
			@(posedge clk);
		repeat (DRAIN)
			@(posedge clk);
	endtask

	task automatic write_active(logic [3:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		score.set_active(v);
		settings_used++;
	endtask

	// Receiver: random stalls, one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_due) begin
				hold_due = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1)
					@(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < idle_pct);
			end
		end
	end

	// Result monitor. Reads at the edge, so it sees the values from before it.
	always @(posedge clk) begin
		assign_res_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.asg   = assignment;
			got.mdist = min_distance;
			got.chg   = changed;
			got.cnt   = cluster_count;
			got.obj   = objective_total;
			got.ctot  = changed_total;
			score.match_result(got);
		end
	end

	// Watchdog: a hung pipe shows up as a long run of cycles with no handshake.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		int c;
		int d;
		int p;
		logic [3:0] plan [8];
		plan = '{4'd1, 4'd0, 4'd15, 4'd9, 4'd3, 4'd8, 4'd7, 4'd5};

		arst_n          <= 1'b0;
		cfg_wr_en       <= 1'b0;
		cfg_wr_data     <= 4'd8;
		in_valid        <= 1'b0;
		action          <= kmna_pkg::ACT_LOAD;
		center_index    <= 3'd0;
		coord_index     <= 4'd0;
		coord_value     <= 16'sd0;
		last_coord      <= 1'b0;
		prev_assignment <= 3'd0;
		out_stall       <= 1'b0;
		hold_due        = 1'b0;
		quiet           = 0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole store; a point reads every center on its dimension.
		for (c = 0; c < NC; c++)
			for (d = 0; d < ND; d++)
				put_word(kmna_pkg::ACT_LOAD, c[2:0], d[3:0], rnd_coord(), 1'b0,
					3'($urandom_range(7)));

		// --- directed, active_centers at its reset value ---

		// all centers equal on dim 5: the tie goes to center 0
		for (c = 0; c < NC; c++)
			put_word(kmna_pkg::ACT_LOAD, c[2:0], 4'd5, 16'sh0100, 1'b0, c[2:0]);
		put_word(kmna_pkg::ACT_POINT, 3'd7, 4'd5, 16'sh0100, 1'b1, 3'd0);
		put_word(kmna_pkg::ACT_POINT, 3'd0, 4'd5, 16'sh8000, 1'b1, 3'd7);

		// centers 6 and 7 tie at zero distance; lower index must win
		put_word(kmna_pkg::ACT_LOAD, 3'd6, 4'd15, 16'sh7FFF, 1'b0, 3'd0);
		put_word(kmna_pkg::ACT_LOAD, 3'd7, 4'd15, 16'sh7FFF, 1'b1, 3'd7);
		put_word(kmna_pkg::ACT_POINT, 3'd0, 4'd15, 16'sh7FFF, 1'b0, 3'd0);
		put_word(kmna_pkg::ACT_POINT, 3'd0, 4'd5, 16'sh0100, 1'b1, 3'd6);

		// unused action with the end mark set: no result
		put_word(ACT_SPARE, 3'd7, 4'd15, 16'shFFFF, 1'b1, 3'd7);

		// clear, then totals start again from zero
		put_word(kmna_pkg::ACT_CLEAR, 3'd0, 4'd0, 16'sd0, 1'b1, 3'd0);
		put_word(kmna_pkg::ACT_POINT, 3'd3, 4'd0, 16'sd0, 1'b0, 3'd3);
		put_word(kmna_pkg::ACT_POINT, 3'd3, 4'd15, 16'shFFFF, 1'b1, 3'd3);

		// every center as far as possible on dim 0; enough coordinates to pin all
		// partial sums at the 40-bit ceiling
		for (c = 0; c < NC; c++)
			put_word(kmna_pkg::ACT_LOAD, c[2:0], 4'd0, 16'sh8000, 1'b0, 3'd0);
		repeat (259)
			put_word(kmna_pkg::ACT_POINT, 3'd0, 4'd0, 16'sh7FFF, 1'b0, 3'd0);
		put_word(kmna_pkg::ACT_POINT, 3'd0, 4'd0, 16'sh7FFF, 1'b1, 3'd0);

		// clear in the middle of a point keeps the partial sums
		put_word(kmna_pkg::ACT_POINT, 3'd2, 4'd9, 16'sh4000, 1'b0, 3'd2);
		put_word(kmna_pkg::ACT_CLEAR, 3'd0, 4'd0, 16'sd0, 1'b0, 3'd0);
		put_word(kmna_pkg::ACT_POINT, 3'd2, 4'd10, 16'shC000, 1'b1, 3'd5);

		random_phase(PHASE_WORDS);

		// --- random phases, one register setting each ---
		for (p = 0; p < 8; p++) begin
			settle();
			write_active(plan[p]);
			idle_pct = (p == 2) ? 0 : IDLE_PCT;
			if (p == 4)
				hold_due = 1'b1;
			random_phase(PHASE_WORDS);
		end
		settle();

		$display("run covered %0d input words: %0d center loads, %0d clears, %0d settings",
			words_sent, score.loads, score.clears, settings_used + 1);
		$display("%0d assignments compared, %0d field mismatches", score.checked,
			score.errors);
		if (score.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
